// ===== src/lcdcs_pkg.sv =====
// Shared types, constants and controller codes for the character display sequencer.
// Depends on nothing; every module of the block imports it.
`timescale 1ns / 1ps

package lcdcs_pkg;

  // display geometry
  localparam int VIS_COLS   = 16;
  localparam int ROW_STRIDE = 40;
  localparam int COL_W      = 4;
  localparam int CNT_W      = 6;
  localparam int NUM_RUNS   = 3;
  localparam int RUN_IDX_W  = 2;

  localparam logic [COL_W-1:0] LAST_COL     = COL_W'(VIS_COLS - 1);
  localparam logic [CNT_W-1:0] ROW_SHIFTS   = CNT_W'(ROW_STRIDE);
  localparam logic [CNT_W-1:0] WRAP_SHIFTS  = CNT_W'(ROW_STRIDE - VIS_COLS);
  localparam logic [CNT_W-1:0] ONE_SHIFT    = CNT_W'(1);

  // controller byte codes
  localparam logic [7:0] CODE_CLEAR       = 8'h01;
  localparam logic [7:0] CODE_SHIFT_RIGHT = 8'h14;
  localparam logic [7:0] CODE_SHIFT_LEFT  = 8'h10;
  localparam logic [7:0] CODE_SPACE       = 8'h20;

  // register select codes
  localparam logic RS_INSTR = 1'b0;
  localparam logic RS_DATA  = 1'b1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef enum logic [2:0] {
    CMD_WRITE_CHAR = 3'd0,
    CMD_CLEAR      = 3'd1,
    CMD_CLEAR_EOL  = 3'd2,
    CMD_UP         = 3'd3,
    CMD_DOWN       = 3'd4,
    CMD_RIGHT      = 3'd5,
    CMD_LEFT       = 3'd6,
    CMD_SET_POS    = 3'd7
  } cmd_t;

  // one run of identical controller writes
  typedef struct packed {
    logic             rs;
    logic [7:0]       byte_val;
    logic [CNT_W-1:0] count;
  } run_t;

  // everything the back end needs to emit the results of one item
  typedef struct packed {
    run_t [NUM_RUNS-1:0]  runs;
    logic [RUN_IDX_W-1:0] n_runs;
    logic                 ok;
    logic                 row;
    logic [COL_W-1:0]     col;
  } plan_t;

  function automatic run_t mk_run(logic rs, logic [7:0] byte_val, logic [CNT_W-1:0] count);
    run_t r;
    r.rs       = rs;
    r.byte_val = byte_val;
    r.count    = count;
    return r;
  endfunction

endpackage

// ===== src/char_lcd_cursor_command_sequencer.sv =====
// Top level of the character display cursor sequencer: front end, plan queue, back end.
// Depends on lcdcs_pkg, lcdcs_front, lcdcs_queue and lcdcs_back.
// Accepted items are registered in the plan queue; out_ ports show the queue head.
// Throughput: one item per cycle while the two-entry plan queue has room; the back end
// gives one result per cycle while out_pop is high, and an item has 1 to 3 results.
// Reset: cursor at the top left, queue empty, no result pending.
`timescale 1ns / 1ps

module char_lcd_cursor_command_sequencer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_push,
  output logic                        in_full,
  input  logic [2:0]                  in_command,
  input  logic [7:0]                  in_char_code,
  input  logic                        in_target_row,
  input  logic [lcdcs_pkg::COL_W-1:0] in_target_column,
  output logic                        out_empty,
  input  logic                        out_pop,
  output logic                        out_has_write,
  output logic                        out_register_select,
  output logic [7:0]                  out_byte_value,
  output logic [lcdcs_pkg::CNT_W-1:0] out_repeat_count,
  output logic                        out_ok,
  output logic                        out_cursor_row,
  output logic [lcdcs_pkg::COL_W-1:0] out_cursor_column,
  output logic                        out_last
);
  import lcdcs_pkg::*;

  plan_t front_plan, head_plan;
  logic  accept, plan_pop;

  assign accept = in_push && !in_full;

  // front end: cursor tracking and classification
  lcdcs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .accept        (accept),
    .command       (in_command),
    .char_code     (in_char_code),
    .target_row    (in_target_row),
    .target_column (in_target_column),
    .plan          (front_plan)
  );

  // plan queue
  lcdcs_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .din   (front_plan),
    .full  (in_full),
    .pop   (plan_pop),
    .dout  (head_plan),
    .empty (out_empty)
  );

  // back end: result sequencing
  lcdcs_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .plan                (head_plan),
    .plan_empty          (out_empty),
    .plan_pop            (plan_pop),
    .out_pop             (out_pop),
    .out_has_write       (out_has_write),
    .out_register_select (out_register_select),
    .out_byte_value      (out_byte_value),
    .out_repeat_count    (out_repeat_count),
    .out_ok              (out_ok),
    .out_cursor_row      (out_cursor_row),
    .out_cursor_column   (out_cursor_column),
    .out_last            (out_last)
  );

  // refused command is a single result with no write
  a_refused_single: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_ok) |-> (!out_has_write && out_last))
    else $error("refused command has a write or more than one result");

  // every write run repeats at least once
  a_run_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_has_write) |-> (out_repeat_count != '0))
    else $error("write result with zero repeat count");

  // an item accepted into an empty block shows up the next cycle
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && out_empty) |=> !out_empty)
    else $error("accepted item did not reach the result side");

  // queue is empty and has room on the first edge after reset is released
  a_reset_state: assert property (@(posedge clk)
    (rst_n && $past(!rst_n)) |-> (out_empty && !in_full))
    else $error("queue not empty after reset");

endmodule

// ===== src/lcdcs_front.sv =====
// Front end: tracks the cursor and turns each accepted item into a plan of write runs.
// Depends on lcdcs_pkg.
`timescale 1ns / 1ps

module lcdcs_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic [2:0]                command,
  input  logic [7:0]                char_code,
  input  logic                      target_row,
  input  logic [lcdcs_pkg::COL_W-1:0] target_column,
  output lcdcs_pkg::plan_t          plan
);
  import lcdcs_pkg::*;

  logic             row_r, row_nxt;
  logic [COL_W-1:0] col_r, col_nxt;
  logic [RUN_IDX_W-1:0] idx;
  logic [COL_W-1:0] eol_cnt;

  // cursor register, top left after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r <= 1'b0;
      col_r <= '0;
    end else if (accept) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  assign eol_cnt = LAST_COL - col_r;

  // classify the command and pack its runs in order
  always_comb begin
    plan    = '0;
    idx     = '0;
    row_nxt = row_r;
    col_nxt = col_r;
    plan.ok = 1'b1;
    unique case (cmd_t'(command))
      CMD_WRITE_CHAR: begin
        plan.runs[idx] = mk_run(RS_DATA, char_code, ONE_SHIFT);
        idx = idx + 1'b1;
        if (col_r == LAST_COL) begin
          // skip the hidden part of the row, wrap to the other row
          plan.runs[idx] = mk_run(RS_INSTR, CODE_SHIFT_RIGHT, WRAP_SHIFTS);
          idx = idx + 1'b1;
          col_nxt = '0;
          row_nxt = ~row_r;
        end else begin
          col_nxt = col_r + 1'b1;
        end
      end
      CMD_CLEAR: begin
        plan.runs[idx] = mk_run(RS_INSTR, CODE_CLEAR, ONE_SHIFT);
        idx = idx + 1'b1;
        row_nxt = 1'b0;
        col_nxt = '0;
      end
      CMD_CLEAR_EOL: begin
        if (col_r == LAST_COL) begin
          plan.ok = 1'b0;
        end else begin
          plan.runs[idx] = mk_run(RS_DATA, CODE_SPACE, CNT_W'(eol_cnt));
          idx = idx + 1'b1;
          plan.runs[idx] = mk_run(RS_INSTR, CODE_SHIFT_LEFT, CNT_W'(eol_cnt));
          idx = idx + 1'b1;
        end
      end
      CMD_UP: begin
        if (!row_r) begin
          plan.ok = 1'b0;
        end else begin
          plan.runs[idx] = mk_run(RS_INSTR, CODE_SHIFT_LEFT, ROW_SHIFTS);
          idx = idx + 1'b1;
          row_nxt = 1'b0;
        end
      end
      CMD_DOWN: begin
        if (row_r) begin
          plan.ok = 1'b0;
        end else begin
          plan.runs[idx] = mk_run(RS_INSTR, CODE_SHIFT_RIGHT, ROW_SHIFTS);
          idx = idx + 1'b1;
          row_nxt = 1'b1;
        end
      end
      CMD_RIGHT: begin
        if (col_r == LAST_COL) begin
          plan.ok = 1'b0;
        end else begin
          plan.runs[idx] = mk_run(RS_INSTR, CODE_SHIFT_RIGHT, ONE_SHIFT);
          idx = idx + 1'b1;
          col_nxt = col_r + 1'b1;
        end
      end
      CMD_LEFT: begin
        if (col_r == '0) begin
          plan.ok = 1'b0;
        end else begin
          plan.runs[idx] = mk_run(RS_INSTR, CODE_SHIFT_LEFT, ONE_SHIFT);
          idx = idx + 1'b1;
          col_nxt = col_r - 1'b1;
        end
      end
      CMD_SET_POS: begin
        if ({1'b0, target_column} >= (COL_W + 1)'(VIS_COLS)) begin
          plan.ok = 1'b0;
        end else begin
          // row change, back to column zero, then out to the target column
          if (target_row != row_r) begin
            plan.runs[idx] = mk_run(RS_INSTR, target_row ? CODE_SHIFT_RIGHT : CODE_SHIFT_LEFT,
                                    ROW_SHIFTS);
            idx = idx + 1'b1;
          end
          if (col_r != '0) begin
            plan.runs[idx] = mk_run(RS_INSTR, CODE_SHIFT_LEFT, CNT_W'(col_r));
            idx = idx + 1'b1;
          end
          if (target_column != '0) begin
            plan.runs[idx] = mk_run(RS_INSTR, CODE_SHIFT_RIGHT, CNT_W'(target_column));
            idx = idx + 1'b1;
          end
          row_nxt = target_row;
          col_nxt = target_column;
        end
      end
      default: plan.ok = 1'b0;
    endcase
    plan.n_runs = idx;
    plan.row    = row_nxt;
    plan.col    = col_nxt;
  end

endmodule

// ===== src/lcdcs_queue.sv =====
// Short plan queue that decouples the front end from the back end.
// Depends on lcdcs_pkg.
`timescale 1ns / 1ps

module lcdcs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  lcdcs_pkg::plan_t din,
  output logic             full,
  input  logic             pop,
  output lcdcs_pkg::plan_t dout,
  output logic             empty
);
  import lcdcs_pkg::*;

  plan_t                entry_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]    count_r;
  logic                 do_push, do_pop;

  assign full    = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entry_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (do_push && !do_pop)      count_r <= count_r + 1'b1;
      else if (do_pop && !do_push) count_r <= count_r - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= din;
  end

endmodule

// ===== src/lcdcs_back.sv =====
// Back end: walks the runs of the plan at the queue head, one result per pop.
// Depends on lcdcs_pkg.
`timescale 1ns / 1ps

module lcdcs_back (
  input  logic                        clk,
  input  logic                        rst_n,
  input  lcdcs_pkg::plan_t            plan,
  input  logic                        plan_empty,
  output logic                        plan_pop,
  input  logic                        out_pop,
  output logic                        out_has_write,
  output logic                        out_register_select,
  output logic [7:0]                  out_byte_value,
  output logic [lcdcs_pkg::CNT_W-1:0] out_repeat_count,
  output logic                        out_ok,
  output logic                        out_cursor_row,
  output logic [lcdcs_pkg::COL_W-1:0] out_cursor_column,
  output logic                        out_last
);
  import lcdcs_pkg::*;

  logic [RUN_IDX_W-1:0] k_r, k_nxt;
  logic [RUN_IDX_W-1:0] last_idx;
  logic                 take;
  run_t                 cur_run;

  // a plan with no runs still yields one result
  assign last_idx = (plan.n_runs == '0) ? '0 : plan.n_runs - 1'b1;
  assign cur_run  = plan.runs[k_r];
  assign take     = out_pop && !plan_empty;

  assign out_has_write       = (plan.n_runs != '0);
  assign out_register_select = cur_run.rs;
  assign out_byte_value      = cur_run.byte_val;
  assign out_repeat_count    = cur_run.count;
  assign out_ok              = plan.ok;
  assign out_cursor_row      = plan.row;
  assign out_cursor_column   = plan.col;
  assign out_last            = (k_r == last_idx);
  assign plan_pop            = take && out_last;

  // run index within the head plan
  always_comb begin
    k_nxt = k_r;
    if (take) k_nxt = out_last ? '0 : k_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) k_r <= '0;
    else        k_r <= k_nxt;
  end

endmodule
